@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL, clocked on clk_i; GB_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define GB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check at every edge, also during reset
`define GB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/gbws_pkg.sv @@
// ----------------------------------------------------------------------------
// gbws_pkg
// Geometry, widths and codes of the glyph blitter and width scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbws_pkg;

  localparam int GLYPH_ROWS      = 18;
  localparam int GLYPH_COLUMNS   = 16;
  localparam int PALETTE_ENTRIES = 16;
  localparam int BYTES_PER_ROW   = (GLYPH_COLUMNS + 1) / 2;

  localparam int COLOR_W = 16;
  localparam int NIB_W   = 4;
  localparam int ORG_W   = 12;
  localparam int POS_W   = ORG_W + 1;
  localparam int GW_W    = 4;
  localparam int PAIR_W  = 2 * NIB_W;

  localparam int BIR_W = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
  localparam int ROW_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int COL_W = $clog2(2 * BYTES_PER_ROW);

  localparam logic [COLOR_W-1:0] KEY_RESET = 16'h001f;

  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_GLYPH   = 1'b1;
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_WIDTH   = 1'b1;

endpackage

@@ rtl/glyph_blit_and_width_scan.sv @@
// ----------------------------------------------------------------------------
// glyph_blit_and_width_scan
// Palettized 4bpp glyph blitter with color key and per-glyph width scan.
// Path: a request is held in the stage-1 register, and each of its results
// then passes through the output register before it is presented.
// Throughput: one result per cycle through the single output register while
// out_ready_i is high; a byte with two opaque pixels, or one ending a glyph,
// holds the stage and new requests until its last result is loaded.
// Reset: counters, origin and widths clear, key returns to 0x1f; palette
// contents are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glyph_blit_and_width_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gbws_pkg::COLOR_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [gbws_pkg::NIB_W-1:0]    entry_index_i,
  input  logic [gbws_pkg::COLOR_W-1:0]  entry_color_i,
  input  logic [gbws_pkg::PAIR_W-1:0]   pixel_pair_i,
  input  logic                          glyph_start_i,
  input  logic [gbws_pkg::ORG_W-1:0]    origin_x_i,
  input  logic [gbws_pkg::ORG_W-1:0]    origin_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic [gbws_pkg::POS_W-1:0]    pixel_x_o,
  output logic [gbws_pkg::POS_W-1:0]    pixel_y_o,
  output logic [gbws_pkg::COLOR_W-1:0]  color_o,
  output logic [gbws_pkg::GW_W-1:0]     glyph_width_o,
  output logic                          last_o
);
  import gbws_pkg::*;

  logic [COLOR_W-1:0] key_q;
  logic [COLOR_W-1:0] pal_mem [PALETTE_ENTRIES];

  logic [BIR_W-1:0] bir_q, bir_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [ORG_W-1:0] lx_q, lx_d, ly_q, ly_d;
  logic [GW_W-1:0]  rw_q, rw_d, mx_q, mx_d;

  logic               s1_valid_q;
  logic [COLOR_W-1:0] s1_c0_q, s1_c1_q;
  logic [COL_W-1:0]   s1_col0_q;
  logic [POS_W-1:0]   s1_px0_q, s1_py_q;
  logic               s1_start_q, s1_eor_q, s1_eog_q;
  logic [2:0]         sent_q, sent_d;

  logic               out_valid_q, kind_q, last_q;
  logic [POS_W-1:0]   px_q, py_q;
  logic [COLOR_W-1:0] color_q;
  logic [GW_W-1:0]    gw_q;

  logic               accept, accept_pal, accept_glyph;
  logic               eor, eog;
  logic [COL_W-1:0]   col0_in;
  logic [COL_W-1:0]   s1_col1;
  logic               opq0, opq1;
  logic [2:0]         req_mask;
  logic               sel0, sel1, sel2, last_sel;
  logic               out_load, s1_done;
  logic [GW_W-1:0]    rw_base, mx_base, rw_new, mx_new;
  logic [POS_W-1:0]   px1;

  // request side
  assign in_ready_o   = !s1_valid_q || s1_done;
  assign accept       = in_valid_i && in_ready_o;
  assign accept_pal   = accept && (mode_i == MODE_PALETTE);
  assign accept_glyph = accept && (mode_i == MODE_GLYPH);

  always_comb begin
    bir_d = glyph_start_i ? '0 : bir_q;
    row_d = glyph_start_i ? '0 : row_q;
    lx_d  = glyph_start_i ? origin_x_i : lx_q;
    ly_d  = glyph_start_i ? origin_y_i : ly_q;
    eor   = (bir_d == BIR_W'(BYTES_PER_ROW - 1));
    eog   = eor && (row_d == ROW_W'(GLYPH_ROWS - 1));
    col0_in = COL_W'(bir_d) << 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KEY_RESET;
    end else if (cfg_we_i) begin
      key_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_pal) begin
      pal_mem[entry_index_i] <= entry_color_i;
    end
    if (accept_glyph) begin
      s1_c0_q <= pal_mem[pixel_pair_i[PAIR_W-1:NIB_W]];
      s1_c1_q <= pal_mem[pixel_pair_i[NIB_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bir_q <= '0;
      row_q <= '0;
      lx_q  <= '0;
      ly_q  <= '0;
    end else if (accept_glyph) begin
      bir_q <= eor ? '0 : bir_d + BIR_W'(1);
      row_q <= eog ? '0 : (eor ? row_d + ROW_W'(1) : row_d);
      lx_q  <= lx_d;
      ly_q  <= ly_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_glyph) begin
      s1_col0_q  <= col0_in;
      s1_px0_q   <= POS_W'(lx_d) + POS_W'(col0_in);
      s1_py_q    <= POS_W'(ly_d) + POS_W'(row_d);
      s1_start_q <= glyph_start_i;
      s1_eor_q   <= eor;
      s1_eog_q   <= eog;
    end
  end

  // result selection
  assign s1_col1 = s1_col0_q | COL_W'(1);
  assign opq0 = ({1'b0, s1_col0_q} < (COL_W+1)'(GLYPH_COLUMNS)) && (s1_c0_q != key_q);
  assign opq1 = ({1'b0, s1_col1} < (COL_W+1)'(GLYPH_COLUMNS)) && (s1_c1_q != key_q);
  assign px1  = s1_px0_q + POS_W'(1);

  always_comb begin
    req_mask = {s1_eog_q, opq1, opq0} & ~sent_q & {3{s1_valid_q}};
    sel0     = req_mask[0];
    sel1     = !req_mask[0] && req_mask[1];
    sel2     = (req_mask == 3'b100);
    if (sel0) begin
      last_sel = (req_mask[2:1] == 2'b00);
    end else if (sel1) begin
      last_sel = !req_mask[2];
    end else begin
      last_sel = 1'b1;
    end
    out_load = (req_mask != 3'b000) && (!out_valid_q || out_ready_i);
    s1_done  = s1_valid_q && ((req_mask == 3'b000) || (out_load && last_sel));
    sent_d   = sent_q;
    if (s1_done) begin
      sent_d = '0;
    end else if (out_load) begin
      sent_d = sent_q | {sel2, sel1, sel0};
    end
  end

  // width scan
  always_comb begin
    rw_base = s1_start_q ? '0 : rw_q;
    mx_base = s1_start_q ? '0 : mx_q;
    if (opq1) begin
      rw_new = GW_W'(s1_col1);
    end else if (opq0) begin
      rw_new = GW_W'(s1_col0_q);
    end else begin
      rw_new = rw_base;
    end
    mx_new = (s1_eor_q && (rw_new > mx_base)) ? rw_new : mx_base;
    rw_d   = s1_eor_q ? '0 : rw_new;
    mx_d   = s1_eog_q ? '0 : mx_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      sent_q     <= '0;
      rw_q       <= '0;
      mx_q       <= '0;
    end else begin
      sent_q <= sent_d;
      if (accept_glyph) begin
        s1_valid_q <= 1'b1;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_done) begin
        rw_q <= rw_d;
        mx_q <= mx_d;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      last_q <= last_sel;
      if (sel2) begin
        kind_q  <= KIND_WIDTH;
        px_q    <= '0;
        py_q    <= '0;
        color_q <= '0;
        gw_q    <= mx_new;
      end else begin
        kind_q  <= KIND_PIXEL;
        px_q    <= sel0 ? s1_px0_q : px1;
        py_q    <= s1_py_q;
        color_q <= sel0 ? s1_c0_q : s1_c1_q;
        gw_q    <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign color_o       = color_q;
  assign glyph_width_o = gw_q;
  assign last_o        = last_q;

  `GB_ASSERT(a_sent_subset, s1_valid_q |-> ((sent_q & ~{s1_eog_q, opq1, opq0}) == 3'b000), "sent results outside request")
  `GB_ASSERT_ALWAYS(a_idle_clean, !s1_valid_q |-> (sent_q == 3'b000), "sent mask left over with empty stage")
  `GB_ASSERT(a_load_shows, out_load |=> out_valid_o, "loaded result not presented")
  `GB_ASSERT(a_empty_ready, !s1_valid_q |-> in_ready_o, "empty stage refuses requests")

endmodule
